// ----- rtl/cpfe_pkg.sv -----
// Shared types, constants and encoder functions for the coded-PHY FEC encoder.
// No dependencies; used by every module of the block.
package cpfe_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned StepW = 4;   // holds up to 13 result steps
	localparam int unsigned SeqW  = 16;  // data bits, CI bit, zero padding

	localparam logic [7:0] S8_PAT_00 = 8'h33;
	localparam logic [7:0] S8_PAT_10 = 8'hc3;  // G0 set
	localparam logic [7:0] S8_PAT_01 = 8'h3c;  // G1 set
	localparam logic [7:0] S8_PAT_11 = 8'hcc;

	localparam logic [StepW-1:0] S8_DATA_STEPS = 4'd8;
	localparam logic [StepW-1:0] S2_DATA_STEPS = 4'd2;
	localparam logic [StepW-1:0] B1_TERM_STEPS = 4'd5;  // CI pair plus TERM1
	localparam logic [StepW-1:0] S8_TERM_STEPS = 4'd3;
	localparam logic [StepW-1:0] S2_TERM_STEPS = 4'd1;

	localparam logic BLOCK_1 = 1'b0;

	// One classified input item, as queued between front and back.
	typedef struct packed {
		logic [DataW-1:0] data;
		logic             s8;
		logic             ci_bit;   // first CI bit of block 1, zero otherwise
		logic [StepW-1:0] n_steps;
		logic [StepW-1:0] n_data;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [2:0] hist;
		logic       g1;
		logic       g0;
	} conv_t;

	// Shift one bit through the K=4 encoder.
	function automatic conv_t conv_bit(input logic [2:0] hist, input logic b);
		conv_t r;
		r.g0   = b ^ hist[0] ^ hist[1] ^ hist[2];
		r.g1   = b ^ hist[1] ^ hist[2];
		r.hist = {hist[1:0], b};
		return r;
	endfunction

	function automatic logic [7:0] s8_map(input logic g0, input logic g1);
		logic [7:0] p;
		case ({g1, g0})
			2'b00:   p = S8_PAT_00;
			2'b01:   p = S8_PAT_10;
			2'b10:   p = S8_PAT_01;
			default: p = S8_PAT_11;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/cpfe_front.sv -----
// Front end: holds the mode register, classifies each input item into a job.
// Depends on cpfe_pkg.
module cpfe_front
	import cpfe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	input  logic             push,
	input  logic             q_full,
	input  logic [DataW-1:0] data_byte,
	input  logic             block_sel,
	input  logic             last_in_block,
	output logic             job_push,
	output job_t             job
);

	logic             mode_s8_q;
	logic             s8;
	logic [StepW-1:0] n_data;
	logic [StepW-1:0] n_term;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s8_q <= 1'b1;
		end else if (cfg_valid) begin
			mode_s8_q <= cfg_data;
		end
	end

	always_comb begin
		s8     = (block_sel == BLOCK_1) || mode_s8_q;
		n_data = s8 ? S8_DATA_STEPS : S2_DATA_STEPS;
		if (!last_in_block) begin
			n_term = '0;
		end else if (block_sel == BLOCK_1) begin
			n_term = B1_TERM_STEPS;
		end else if (s8) begin
			n_term = S8_TERM_STEPS;
		end else begin
			n_term = S2_TERM_STEPS;
		end
		job.data    = data_byte;
		job.s8      = s8;
		// CI is 2 (first bit set) when block 2 runs in S2
		job.ci_bit  = (block_sel == BLOCK_1) && !mode_s8_q;
		job.n_data  = n_data;
		job.n_steps = n_data + n_term;
	end

	assign job_push = push && !q_full;

endmodule

// ----- rtl/cpfe_queue.sv -----
// Two-entry job queue between the front end and the encoder back end.
// Depends on cpfe_pkg.
module cpfe_queue
	import cpfe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_ctl_t  ctl,
	input  job_t    wr_job,
	output job_t    rd_job,
	output q_stat_t stat
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({ctl.push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/cpfe_back.sv -----
// Back end: steps through each job, runs the convolutional encoder and the
// pattern map, one result byte per step, into the output register.
// Depends on cpfe_pkg.
module cpfe_back
	import cpfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       job_empty,
	output logic       job_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] code_byte,
	output logic       term_byte,
	output logic       last_of_run
);

	logic [2:0]       hist_q;
	logic [StepW-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       code_q;
	logic             term_q;
	logic             last_q;

	logic             out_free;
	logic             step;
	logic             step_last;
	logic [SeqW-1:0]  seq;
	logic [3:0]       nib;
	logic [2:0]       hist_nx;
	logic [7:0]       code_nx;
	conv_t            cv;
	logic [2:0]       h;
	logic [7:0]       acc;

	assign out_free  = !out_valid_q || pop;
	assign step      = !job_empty && out_free;
	assign step_last = (idx_q == job.n_steps - 4'd1);
	assign job_pop   = step && step_last;

	always_comb begin
		seq = {job.data, job.ci_bit, 7'b0};
		case (idx_q[1:0])
			2'd0:    nib = seq[15:12];
			2'd1:    nib = seq[11:8];
			2'd2:    nib = seq[7:4];
			default: nib = seq[3:0];
		endcase
		h   = hist_q;
		acc = '0;
		cv  = '0;
		if (job.s8) begin
			cv      = conv_bit(hist_q, seq[4'(4'd15 - idx_q)]);
			hist_nx = cv.hist;
			code_nx = s8_map(cv.g0, cv.g1);
		end else begin
			// four code pairs per byte, G0 in the upper bit of each pair
			for (int i = 3; i >= 0; i--) begin
				cv  = conv_bit(h, nib[i]);
				h   = cv.hist;
				acc = {acc[5:0], cv.g0, cv.g1};
			end
			hist_nx = h;
			code_nx = acc;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			code_q <= code_nx;
			term_q <= (idx_q >= job.n_data);
			last_q <= step_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				hist_q <= hist_nx;
				idx_q  <= step_last ? '0 : idx_q + 4'd1;
			end
			if (out_free) begin
				out_valid_q <= step;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign code_byte   = code_q;
	assign term_byte   = term_q;
	assign last_of_run = last_q;

endmodule

// ----- rtl/coded_phy_fec_pattern_encoder.sv -----
// Top level of the coded-PHY FEC encoder with S8/S2 pattern mapping.
// Depends on cpfe_pkg, cpfe_front, cpfe_queue and cpfe_back.
//
// Usage:
//   Input queue side: drive data_byte, block_sel and last_in_block and raise
//   push; the item is taken at a clock edge with push high and full low.
//   Result queue side: while empty is low the oldest result item sits on
//   code_byte, term_byte and last_of_run; take it by raising pop.
//   Configuration: cfg_data sets the block 2 mode (1 = S8, 0 = S2), written
//   on cfg_valid; cfg_ready is always high. Write only while the block idles.
// Path: with the back end idle, an item taken is first written into the job
//   queue, then its first result is registered into the output register.
// Throughput: one result byte per cycle while a job waits and the output is
//   free or popped, set by the single encoder step unit in the back end. An
//   item gives 8 result bytes in S8, 2 in S2, plus 5 of CI and TERM1 at the
//   end of block 1, 3 (S8) or 1 (S2) of TERM2 at block 2's end; 13 at most.
// A two-entry job queue sits between the front and back ends, so new items
//   are taken while earlier ones are still being encoded.
// Reset: clears encoder history, both queues and sets the mode to S8.
// Stalls: when pop stays low the output register holds its item and the
//   back end pauses; items keep being taken until the job queue fills.
module coded_phy_fec_pattern_encoder
	import cpfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       block_sel,
	input  logic       last_in_block,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] code_byte,
	output logic       term_byte,
	output logic       last_of_run
);

	job_t    wr_job;
	job_t    rd_job;
	q_ctl_t  q_ctl;
	q_stat_t q_stat;
	logic    job_push;
	logic    job_pop;

	// front: classify each item into step counts and mode
	cpfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.q_full       (q_stat.full),
		.data_byte    (data_byte),
		.block_sel    (block_sel),
		.last_in_block(last_in_block),
		.job_push     (job_push),
		.job          (wr_job)
	);

	assign q_ctl.push = job_push;
	assign q_ctl.pop  = job_pop;
	assign full       = q_stat.full;

	// hold up to two classified items while the back end works
	cpfe_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (q_ctl),
		.wr_job(wr_job),
		.rd_job(rd_job),
		.stat  (q_stat)
	);

	// back: encode and pattern map, one result per cycle while the output is popped
	cpfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (rd_job),
		.job_empty  (q_stat.empty),
		.job_pop    (job_pop),
		.pop        (pop),
		.empty      (empty),
		.code_byte  (code_byte),
		.term_byte  (term_byte),
		.last_of_run(last_of_run)
	);

endmodule
